// File: hw/rtl/hfbs_pkg.sv
`timescale 1ns / 1ps
package hfbs_pkg;

  localparam int unsigned CFG_W       = 13;
  localparam int unsigned POS_W       = 12;
  localparam int unsigned SUM_W       = 29;
  localparam int unsigned CNT_W       = 20;
  localparam int unsigned CH_W        = 8;
  localparam int unsigned Q8_W        = 18;
  localparam int unsigned OCNT_W      = 19;
  localparam int unsigned DVD_W       = 35;
  localparam int unsigned DVS_W       = 20;
  localparam int unsigned DIV_STEPS   = DVD_W;
  localparam int unsigned STEP_CNT_W  = $clog2(DIV_STEPS);
  localparam int unsigned PCT_W       = 15;
  localparam int unsigned PHASE_W     = 3;
  localparam int unsigned IDX_W       = 2;
  localparam int unsigned MEAN_W      = 10;
  localparam int unsigned THIRD_PROD_W = 2 * MEAN_W + 1;
  localparam int unsigned THIRD_SHIFT = 11;

  localparam logic [CFG_W-1:0] MAX_WIDTH    = 13'd4096;
  localparam logic [CFG_W-1:0] MAX_HEIGHT   = 13'd4096;
  localparam logic [CFG_W-1:0] MIN_WIDTH    = 13'd1;
  localparam logic [CFG_W-1:0] MIN_HEIGHT   = 13'd2;
  localparam logic [CFG_W-1:0] WIDTH_RST    = 13'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RST   = 13'd480;
  localparam logic [PHASE_W-1:0] SAMPLE_LAST = 3'd4;
  localparam logic [CH_W-1:0]  BRIGHT_LEVEL = 8'd250;
  localparam logic [CH_W-1:0]  DARK_LEVEL   = 8'd25;
  localparam logic [PCT_W-1:0] PERCENT_Q8   = 15'd25600;
  localparam logic [DVS_W-1:0] PIXEL_BYTES  = 20'd3;
  localparam logic [MEAN_W:0]  THIRD_RECIP  = 11'd683;

  typedef enum logic [IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_UPPER  = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_MUL,
    ST_PCT_GO,
    ST_PCT_WAIT
  } state_t;

  typedef struct packed {
    logic [CFG_W-1:0] width;
    logic [CFG_W-1:0] height;
    logic             upper;
  } geom_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] bright;
    logic [CNT_W-1:0] dark;
  } stats_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

// File: hw/rtl/hfbs_if.sv
`timescale 1ns / 1ps
interface hfbs_pix_if;
  logic                      valid;
  logic                      ready;
  logic [hfbs_pkg::CH_W-1:0] red;
  logic [hfbs_pkg::CH_W-1:0] green;
  logic [hfbs_pkg::CH_W-1:0] blue;
  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface hfbs_res_if;
  logic                               valid;
  logic                               ready;
  logic signed [hfbs_pkg::Q8_W-1:0]   brightness_q8;
  logic [hfbs_pkg::OCNT_W-1:0]        sample_count;
  modport source (output valid, output brightness_q8, output sample_count, input ready);
  modport sink (input valid, input brightness_q8, input sample_count, output ready);
endinterface

interface hfbs_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [hfbs_pkg::IDX_W-1:0] index;
  logic [hfbs_pkg::CFG_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/hfbs_div.sv
`timescale 1ns / 1ps
module hfbs_div (
  input  logic               clk,
  input  logic               rst,
  input  hfbs_pkg::div_req_t req,
  output hfbs_pkg::div_rsp_t rsp
);
  import hfbs_pkg::*;

  logic [DVD_W-1:0]      dvd;
  logic [DVS_W-1:0]      dvs;
  logic [DVS_W-1:0]      rem;
  logic [STEP_CNT_W-1:0] cnt;
  logic                  busy;
  logic                  done;

  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   trial;
  logic             qbit;

  // one quotient bit per cycle, restoring
  always_comb begin
    shifted = {rem, dvd[DVD_W-1]};
    trial   = shifted - {1'b0, dvs};
    qbit    = ~trial[DVS_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= STEP_CNT_W'(DIV_STEPS - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      dvs <= req.divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= qbit ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
      dvd <= {dvd[DVD_W-2:0], qbit};
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = dvd;

endmodule

// File: hw/rtl/hfbs_acc.sv
`timescale 1ns / 1ps
module hfbs_acc (
  input  logic                      clk,
  input  logic                      rst,
  input  hfbs_pkg::geom_t           geom,
  input  logic                      take,
  input  logic                      clear,
  input  logic [hfbs_pkg::CH_W-1:0] red,
  input  logic [hfbs_pkg::CH_W-1:0] green,
  input  logic [hfbs_pkg::CH_W-1:0] blue,
  output logic                      frame_end,
  output hfbs_pkg::stats_t          stats
);
  import hfbs_pkg::*;

  function automatic logic [PHASE_W-1:0] mod5(input logic [POS_W-1:0] v);
    logic [5:0] s;
    logic [4:0] t;
    s = 6'(v[3:0]) + 6'(v[7:4]) + 6'(v[11:8]);
    t = 5'(s[5:4]) + 5'(s[3:0]);
    if (t >= 5'd15) begin
      t = t - 5'd15;
    end else if (t >= 5'd10) begin
      t = t - 5'd10;
    end else if (t >= 5'd5) begin
      t = t - 5'd5;
    end
    return t[PHASE_W-1:0];
  endfunction

  logic [POS_W-1:0]   column_pos;
  logic [POS_W-1:0]   row_pos;
  logic [PHASE_W-1:0] col_phase;
  logic [PHASE_W-1:0] row_phase;
  stats_t             acc;

  logic [CFG_W-1:0]   half;
  logic [CFG_W-1:0]   first;
  logic [CFG_W-1:0]   last_row;
  logic [PHASE_W-1:0] first_phase;
  logic               row_end;
  logic               sampled;
  logic               is_bright;
  logic               is_dark;

  always_comb begin
    half        = geom.height >> 1;
    first       = geom.upper ? '0 : half;
    last_row    = first + half;
    first_phase = geom.upper ? '0 : mod5(half[POS_W-1:0]);
    row_end     = {1'b0, column_pos} >= geom.width - 1'b1;
    frame_end   = row_end && ({1'b0, row_pos} >= geom.height - 1'b1);
    sampled     = ({1'b0, row_pos} >= first) && ({1'b0, row_pos} < last_row) &&
                  (row_phase == first_phase) && ({1'b0, column_pos} < geom.width) &&
                  (col_phase == '0);
    is_bright   = (red >= BRIGHT_LEVEL) && (green >= BRIGHT_LEVEL) &&
                  (blue >= BRIGHT_LEVEL);
    is_dark     = (red <= DARK_LEVEL) && (green <= DARK_LEVEL) && (blue <= DARK_LEVEL);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_pos <= '0;
      row_pos    <= '0;
      col_phase  <= '0;
      row_phase  <= '0;
      acc        <= '0;
    end else if (clear) begin
      acc <= '0;
    end else if (take) begin
      if (sampled) begin
        acc.sum   <= acc.sum + SUM_W'(red) + SUM_W'(green) + SUM_W'(blue);
        acc.count <= acc.count + 1'b1;
        if (is_bright) begin
          acc.bright <= acc.bright + 1'b1;
        end
        if (is_dark) begin
          acc.dark <= acc.dark + 1'b1;
        end
      end
      if (frame_end) begin
        column_pos <= '0;
        row_pos    <= '0;
        col_phase  <= '0;
        row_phase  <= '0;
      end else if (row_end) begin
        column_pos <= '0;
        col_phase  <= '0;
        row_pos    <= row_pos + 1'b1;
        row_phase  <= (row_phase == SAMPLE_LAST) ? '0 : row_phase + 1'b1;
      end else begin
        column_pos <= column_pos + 1'b1;
        col_phase  <= (col_phase == SAMPLE_LAST) ? '0 : col_phase + 1'b1;
      end
    end
  end

  assign stats = acc;

endmodule

// File: hw/rtl/half_frame_brightness_stats_top.sv
`timescale 1ns / 1ps
// pixels are taken one per cycle while ready is high; each updates the position and
// accumulators at once; the last pixel of a frame starts the result sequence: sum/count
// on the shared divider, a multiply step, then the percentage divide; pixel ready is low
// while the sequence runs; the result beat follows the percentage divide, or the first
// step for a frame with no samples; the next frame may start while it waits
// synchronous active-high reset clears position, accumulators, sequencer; 640x480, upper half
module half_frame_brightness_stats_top (
  input  logic clk,
  input  logic rst,
  hfbs_pix_if.sink   pix,
  hfbs_res_if.source res,
  hfbs_cfg_if.sink   cfg
);
  import hfbs_pkg::*;

  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  logic             upper_reg;
  geom_t            geom;

  state_t state;
  state_t state_next;

  div_req_t div_req;
  div_rsp_t div_rsp;
  stats_t   stats;
  logic     frame_end;
  logic     take;
  logic     acc_clear;
  logic     out_load;
  logic     zero_result;

  logic [THIRD_PROD_W-1:0] third_prod;
  logic [CH_W-1:0]       mean;
  logic                  diff_neg;
  logic [DVD_W-1:0]      product;
  logic                  out_valid;
  logic signed [Q8_W-1:0] out_q8;
  logic [OCNT_W-1:0]     out_count;

  logic signed [CNT_W:0]  diff;
  logic [CNT_W-1:0]       diff_abs;
  logic signed [Q8_W-1:0] pct;
  logic signed [Q8_W-1:0] result;

  // configuration
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= WIDTH_RST;
      height_reg <= HEIGHT_RST;
      upper_reg  <= 1'b1;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_WIDTH:  width_reg  <= cfg.data;
        CFG_HEIGHT: height_reg <= cfg.data;
        CFG_UPPER:  upper_reg  <= cfg.data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    geom.width  = (width_reg < MIN_WIDTH) ? MIN_WIDTH :
                  (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    geom.height = (height_reg < MIN_HEIGHT) ? MIN_HEIGHT :
                  (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
    geom.upper  = upper_reg;
  end

  assign take = pix.valid && pix.ready;

  hfbs_acc u_acc (
    .clk       (clk),
    .rst       (rst),
    .geom      (geom),
    .take      (take),
    .clear     (acc_clear),
    .red       (pix.red),
    .green     (pix.green),
    .blue      (pix.blue),
    .frame_end (frame_end),
    .stats     (stats)
  );

  hfbs_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:       if (take && frame_end) state_next = ST_MEAN_GO;
      ST_MEAN_GO:    state_next = (stats.count == '0) ? ST_IDLE : ST_MEAN_WAIT;
      ST_MEAN_WAIT:  if (div_rsp.done) state_next = ST_MUL;
      ST_MUL:        state_next = ST_PCT_GO;
      ST_PCT_GO:     state_next = ST_PCT_WAIT;
      ST_PCT_WAIT:   if (div_rsp.done) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pix.ready        = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = DVD_W'(stats.sum);
    div_req.divisor  = stats.count;
    acc_clear        = 1'b0;
    out_load         = 1'b0;
    zero_result      = 1'b0;
    case (state)
      ST_IDLE: begin
        pix.ready = !(frame_end && out_valid);
      end
      ST_MEAN_GO: begin
        if (stats.count == '0) begin
          out_load    = 1'b1;
          zero_result = 1'b1;
          acc_clear   = 1'b1;
        end else begin
          div_req.start = 1'b1;
        end
      end
      ST_PCT_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = product;
      end
      ST_PCT_WAIT: begin
        if (div_rsp.done) begin
          out_load  = 1'b1;
          acc_clear = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // datapath around the divider
  always_comb begin
    // floor(x/3) by reciprocal, exact for x below 2048
    third_prod = THIRD_PROD_W'(div_rsp.quotient[MEAN_W-1:0]) * THIRD_PROD_W'(THIRD_RECIP);
    diff     = $signed({1'b0, stats.bright}) - $signed({1'b0, stats.dark});
    diff_abs = diff[CNT_W] ? CNT_W'(-diff) : diff[CNT_W-1:0];
    pct      = $signed({3'b0, div_rsp.quotient[PCT_W-1:0]});
    result   = $signed({2'b0, mean, 8'b0}) + (diff_neg ? -pct : pct);
  end

  always_ff @(posedge clk) begin
    if (state == ST_MEAN_WAIT && div_rsp.done) begin
      mean <= third_prod[THIRD_SHIFT +: CH_W];
    end
    if (state == ST_MUL) begin
      product  <= DVD_W'(diff_abs) * DVD_W'(PERCENT_Q8);
      diff_neg <= diff[CNT_W];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_q8    <= zero_result ? '0 : result;
      out_count <= stats.count[OCNT_W-1:0];
    end
  end

  assign res.valid         = out_valid;
  assign res.brightness_q8 = out_q8;
  assign res.sample_count  = out_count;

`ifndef SYNTHESIS
  a_no_pixel_in_sequence: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !pix.ready)
    else $error("pixel ready during result sequence");

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_load_slot_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> !out_valid)
    else $error("result overwritten before taken");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_PCT_WAIT || $past(state) == ST_MEAN_GO))
    else $error("result beat from wrong sequencer state");
`endif

endmodule
